// ===== hw/rtl/rima_pkg.sv =====
// ----------------------------------------------------------------------------
// rima_pkg
// Shared widths, command/status types and a helper for the raw image moment
// accumulator.
// ----------------------------------------------------------------------------
package rima_pkg;

    localparam int MAX_DIM = 1024;
    localparam int COORD_W = $clog2(MAX_DIM);
    localparam int DIM_W   = 11;
    localparam int PIX_W   = 8;

    localparam int SQ_W   = 2 * COORD_W;
    localparam int CUBE_W = 3 * COORD_W;
    localparam int T1_W   = PIX_W + COORD_W;
    localparam int T2_W   = PIX_W + SQ_W;
    localparam int T3_W   = PIX_W + CUBE_W;

    localparam int ACC00_W = 28;
    localparam int ACC10_W = 37;
    localparam int ACC01_W = 37;
    localparam int ACC20_W = 47;
    localparam int ACC11_W = 46;
    localparam int ACC02_W = 47;
    localparam int ACC30_W = 57;
    localparam int ACC21_W = 56;
    localparam int ACC12_W = 56;
    localparam int ACC03_W = 57;

    localparam int M00_W = 28;
    localparam int M10_W = 37;
    localparam int M01_W = 37;
    localparam int M20_W = 47;
    localparam int M11_W = 46;
    localparam int M02_W = 47;
    localparam int M30_W = 56;
    localparam int M21_W = 56;
    localparam int M12_W = 56;
    localparam int M03_W = 56;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    typedef struct packed {
        logic capture;
        logic mul1;
        logic mul2;
        logic mul3;
        logic accum;
    } rima_cmd_t;

    typedef struct packed {
        logic frame_end;
    } rima_sts_t;

    // last valid coordinate for a configured dimension, clamped to 1..MAX_DIM
    function automatic logic [COORD_W-1:0] dim_last(input logic [DIM_W-1:0] dim);
        logic [COORD_W-1:0] r;
        if (dim == '0)
        begin
            r = '0;
        end
        else if (dim > DIM_W'(MAX_DIM))
        begin
            r = COORD_W'(MAX_DIM - 1);
        end
        else
        begin
            r = COORD_W'(dim - DIM_W'(1));
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/rima_ctrl.sv =====
// ----------------------------------------------------------------------------
// rima_ctrl
// Sequencer: steps one pixel through three multiply stages and the
// accumulate stage, and owns the input ready and result valid flags.
// ----------------------------------------------------------------------------
module rima_ctrl
    import rima_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pixel_valid,
    output logic      pixel_ready,
    output logic      moment_valid,
    input  logic      moment_ready,
    input  rima_sts_t sts,
    output rima_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_MUL3 = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       acc_go;

    // accumulate may proceed unless a new result would overwrite an untaken one
    assign acc_go = (state_reg == S_ACC) &&
                    !(sts.frame_end && out_valid_reg && !moment_ready);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        pixel_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                pixel_ready = 1'b1;
                if (pixel_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (acc_go)
                begin
                    cmd.accum  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (moment_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (acc_go && sts.frame_end)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign moment_valid = out_valid_reg;

endmodule

// ===== hw/rtl/rima_datapath.sv =====
// ----------------------------------------------------------------------------
// rima_datapath
// Coordinate counters, size registers, staged power products, the ten
// moment accumulators and the result register.
// ----------------------------------------------------------------------------
module rima_datapath
    import rima_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rima_cmd_t            cmd,
    output rima_sts_t            sts,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic [PIX_W-1:0]     pixel,
    output logic [M00_W-1:0]     moment_00,
    output logic [M10_W-1:0]     moment_10,
    output logic [M01_W-1:0]     moment_01,
    output logic [M20_W-1:0]     moment_20,
    output logic [M11_W-1:0]     moment_11,
    output logic [M02_W-1:0]     moment_02,
    output logic [M30_W-1:0]     moment_30,
    output logic [M21_W-1:0]     moment_21,
    output logic [M12_W-1:0]     moment_12,
    output logic [M03_W-1:0]     moment_03
);

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] col_next;
    logic [COORD_W-1:0] row_next;
    logic               row_end;

    logic [PIX_W-1:0]  pix_reg;
    logic [SQ_W-1:0]   x2_reg;
    logic [SQ_W-1:0]   y2_reg;
    logic [SQ_W-1:0]   xy_reg;
    logic [T1_W-1:0]   px_reg;
    logic [T1_W-1:0]   py_reg;
    logic [CUBE_W-1:0] x3_reg;
    logic [CUBE_W-1:0] x2y_reg;
    logic [CUBE_W-1:0] xy2_reg;
    logic [CUBE_W-1:0] y3_reg;
    logic [T2_W-1:0]   px2_reg;
    logic [T2_W-1:0]   pxy_reg;
    logic [T2_W-1:0]   py2_reg;
    logic [T3_W-1:0]   px3_reg;
    logic [T3_W-1:0]   px2y_reg;
    logic [T3_W-1:0]   pxy2_reg;
    logic [T3_W-1:0]   py3_reg;

    logic [ACC00_W-1:0] acc00_reg;
    logic [ACC10_W-1:0] acc10_reg;
    logic [ACC01_W-1:0] acc01_reg;
    logic [ACC20_W-1:0] acc20_reg;
    logic [ACC11_W-1:0] acc11_reg;
    logic [ACC02_W-1:0] acc02_reg;
    logic [ACC30_W-1:0] acc30_reg;
    logic [ACC21_W-1:0] acc21_reg;
    logic [ACC12_W-1:0] acc12_reg;
    logic [ACC03_W-1:0] acc03_reg;

    logic [ACC00_W-1:0] acc00_next;
    logic [ACC10_W-1:0] acc10_next;
    logic [ACC01_W-1:0] acc01_next;
    logic [ACC20_W-1:0] acc20_next;
    logic [ACC11_W-1:0] acc11_next;
    logic [ACC02_W-1:0] acc02_next;
    logic [ACC30_W-1:0] acc30_next;
    logic [ACC21_W-1:0] acc21_next;
    logic [ACC12_W-1:0] acc12_next;
    logic [ACC03_W-1:0] acc03_next;

    assign row_end       = (col_reg >= dim_last(width_reg));
    assign sts.frame_end = row_end && (row_reg >= dim_last(height_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else if (cfg_index == REG_IMAGE_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    // staged products
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg <= pixel;
        end
        if (cmd.mul1)
        begin
            x2_reg <= SQ_W'(col_reg) * SQ_W'(col_reg);
            y2_reg <= SQ_W'(row_reg) * SQ_W'(row_reg);
            xy_reg <= SQ_W'(col_reg) * SQ_W'(row_reg);
            px_reg <= T1_W'(pix_reg) * T1_W'(col_reg);
            py_reg <= T1_W'(pix_reg) * T1_W'(row_reg);
        end
        if (cmd.mul2)
        begin
            x3_reg  <= CUBE_W'(x2_reg) * CUBE_W'(col_reg);
            x2y_reg <= CUBE_W'(x2_reg) * CUBE_W'(row_reg);
            xy2_reg <= CUBE_W'(y2_reg) * CUBE_W'(col_reg);
            y3_reg  <= CUBE_W'(y2_reg) * CUBE_W'(row_reg);
            px2_reg <= T2_W'(pix_reg) * T2_W'(x2_reg);
            pxy_reg <= T2_W'(pix_reg) * T2_W'(xy_reg);
            py2_reg <= T2_W'(pix_reg) * T2_W'(y2_reg);
        end
        if (cmd.mul3)
        begin
            px3_reg  <= T3_W'(pix_reg) * T3_W'(x3_reg);
            px2y_reg <= T3_W'(pix_reg) * T3_W'(x2y_reg);
            pxy2_reg <= T3_W'(pix_reg) * T3_W'(xy2_reg);
            py3_reg  <= T3_W'(pix_reg) * T3_W'(y3_reg);
        end
    end

    always_comb
    begin
        acc00_next = acc00_reg + ACC00_W'(pix_reg);
        acc10_next = acc10_reg + ACC10_W'(px_reg);
        acc01_next = acc01_reg + ACC01_W'(py_reg);
        acc20_next = acc20_reg + ACC20_W'(px2_reg);
        acc11_next = acc11_reg + ACC11_W'(pxy_reg);
        acc02_next = acc02_reg + ACC02_W'(py2_reg);
        acc30_next = acc30_reg + ACC30_W'(px3_reg);
        acc21_next = acc21_reg + ACC21_W'(px2y_reg);
        acc12_next = acc12_reg + ACC12_W'(pxy2_reg);
        acc03_next = acc03_reg + ACC03_W'(py3_reg);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (sts.frame_end)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (row_end)
        begin
            col_next = '0;
            row_next = row_reg + COORD_W'(1);
        end
        else
        begin
            col_next = col_reg + COORD_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            acc00_reg <= '0;
            acc10_reg <= '0;
            acc01_reg <= '0;
            acc20_reg <= '0;
            acc11_reg <= '0;
            acc02_reg <= '0;
            acc30_reg <= '0;
            acc21_reg <= '0;
            acc12_reg <= '0;
            acc03_reg <= '0;
        end
        else if (cmd.accum)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (sts.frame_end)
            begin
                acc00_reg <= '0;
                acc10_reg <= '0;
                acc01_reg <= '0;
                acc20_reg <= '0;
                acc11_reg <= '0;
                acc02_reg <= '0;
                acc30_reg <= '0;
                acc21_reg <= '0;
                acc12_reg <= '0;
                acc03_reg <= '0;
            end
            else
            begin
                acc00_reg <= acc00_next;
                acc10_reg <= acc10_next;
                acc01_reg <= acc01_next;
                acc20_reg <= acc20_next;
                acc11_reg <= acc11_next;
                acc02_reg <= acc02_next;
                acc30_reg <= acc30_next;
                acc21_reg <= acc21_next;
                acc12_reg <= acc12_next;
                acc03_reg <= acc03_next;
            end
        end
    end

    // result register, loaded with the sums that include the frame's last pixel
    always_ff @(posedge clk)
    begin
        if (cmd.accum && sts.frame_end)
        begin
            moment_00 <= M00_W'(acc00_next);
            moment_10 <= M10_W'(acc10_next);
            moment_01 <= M01_W'(acc01_next);
            moment_20 <= M20_W'(acc20_next);
            moment_11 <= M11_W'(acc11_next);
            moment_02 <= M02_W'(acc02_next);
            moment_30 <= M30_W'(acc30_next);
            moment_21 <= M21_W'(acc21_next);
            moment_12 <= M12_W'(acc12_next);
            moment_03 <= M03_W'(acc03_next);
        end
    end

endmodule

// ===== hw/rtl/raw_image_moment_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// raw_image_moment_accumulator_top
// Raw image moments up to order three over a raster-order 8-bit frame.
// Result valid is registered once a frame's last pixel has passed the multiply
// and accumulate stages; later only while an earlier result still waits for its
// transfer. A new pixel is taken only after the previous one has passed the
// capture, three multiply stages and the accumulate stage of the sequencer.
// Reset clears counters and sums; width and height return to 1024.
// ----------------------------------------------------------------------------
module raw_image_moment_accumulator_top
    import rima_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 pixel_valid,
    output logic                 pixel_ready,
    input  logic [PIX_W-1:0]     pixel,
    output logic                 moment_valid,
    input  logic                 moment_ready,
    output logic [M00_W-1:0]     moment_00,
    output logic [M10_W-1:0]     moment_10,
    output logic [M01_W-1:0]     moment_01,
    output logic [M20_W-1:0]     moment_20,
    output logic [M11_W-1:0]     moment_11,
    output logic [M02_W-1:0]     moment_02,
    output logic [M30_W-1:0]     moment_30,
    output logic [M21_W-1:0]     moment_21,
    output logic [M12_W-1:0]     moment_12,
    output logic [M03_W-1:0]     moment_03
);

    rima_cmd_t cmd;
    rima_sts_t sts;

    assign cfg_ready = 1'b1;

    rima_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .moment_valid (moment_valid),
        .moment_ready (moment_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    rima_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .moment_00 (moment_00),
        .moment_10 (moment_10),
        .moment_01 (moment_01),
        .moment_20 (moment_20),
        .moment_11 (moment_11),
        .moment_02 (moment_02),
        .moment_30 (moment_30),
        .moment_21 (moment_21),
        .moment_12 (moment_12),
        .moment_03 (moment_03)
    );

endmodule

// ===== hw/rtl/rima_checker.sv =====
// ----------------------------------------------------------------------------
// rima_checker
// Port-level checks for the moment accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module rima_checker
    import rima_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 pixel_valid,
    input logic                 pixel_ready,
    input logic                 moment_valid,
    input logic                 moment_ready,
    input logic [M00_W-1:0]     moment_00,
    input logic [M10_W-1:0]     moment_10,
    input logic [M01_W-1:0]     moment_01,
    input logic [M20_W-1:0]     moment_20,
    input logic [M11_W-1:0]     moment_11,
    input logic [M02_W-1:0]     moment_02,
    input logic [M30_W-1:0]     moment_30,
    input logic [M21_W-1:0]     moment_21,
    input logic [M12_W-1:0]     moment_12,
    input logic [M03_W-1:0]     moment_03
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        moment_valid && !moment_ready |=> moment_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        moment_valid && !moment_ready |=>
            $stable(moment_00) && $stable(moment_10) && $stable(moment_01) &&
            $stable(moment_20) && $stable(moment_11) && $stable(moment_02) &&
            $stable(moment_30) && $stable(moment_21) && $stable(moment_12) &&
            $stable(moment_03))
        else $error("result changed while stalled");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> !pixel_ready)
        else $error("pixel taken while previous one in flight");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(moment_valid) |-> $past(pixel_valid && pixel_ready, 5))
        else $error("result not preceded by pixel transfer");

endmodule

bind raw_image_moment_accumulator_top rima_checker u_rima_checker (.*);

// ===== sim/rima_moment_checker.sv =====
// ----------------------------------------------------------------------------
// rima_moment_checker
// Watches the configuration, pixel and moment channels of the raw image moment
// accumulator. Tracks frame size and raster position, sums the ten moments of
// every transferred pixel and compares each emitted result, field by field,
// with the oldest completed frame.
// ----------------------------------------------------------------------------
module rima_moment_checker
    import rima_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 pixel_valid,
    input  logic                 pixel_ready,
    input  logic [PIX_W-1:0]     pixel,
    input  logic                 moment_valid,
    input  logic                 moment_ready,
    input  logic [M00_W-1:0]     moment_00,
    input  logic [M10_W-1:0]     moment_10,
    input  logic [M01_W-1:0]     moment_01,
    input  logic [M20_W-1:0]     moment_20,
    input  logic [M11_W-1:0]     moment_11,
    input  logic [M02_W-1:0]     moment_02,
    input  logic [M30_W-1:0]     moment_30,
    input  logic [M21_W-1:0]     moment_21,
    input  logic [M12_W-1:0]     moment_12,
    input  logic [M03_W-1:0]     moment_03,
    output int                   mismatch_count,
    output int                   outstanding,
    output int                   frames_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [M00_W-1:0] m00;
        logic [M10_W-1:0] m10;
        logic [M01_W-1:0] m01;
        logic [M20_W-1:0] m20;
        logic [M11_W-1:0] m11;
        logic [M02_W-1:0] m02;
        logic [M30_W-1:0] m30;
        logic [M21_W-1:0] m21;
        logic [M12_W-1:0] m12;
        logic [M03_W-1:0] m03;
    } moments_t;

    moments_t frame_moments_q[$];

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;

    logic [ACC00_W-1:0] sum_00;
    logic [ACC10_W-1:0] sum_10;
    logic [ACC01_W-1:0] sum_01;
    logic [ACC20_W-1:0] sum_20;
    logic [ACC11_W-1:0] sum_11;
    logic [ACC02_W-1:0] sum_02;
    logic [ACC30_W-1:0] sum_30;
    logic [ACC21_W-1:0] sum_21;
    logic [ACC12_W-1:0] sum_12;
    logic [ACC03_W-1:0] sum_03;

    int errors;
    int frames_seen;

    // zero counts as one, anything above MAX_DIM as MAX_DIM
    function automatic logic [COORD_W-1:0] last_coord(input logic [DIM_W-1:0] dim);
        int d;
        d = int'(dim);
        if (d < 1)
        begin
            d = 1;
        end
        if (d > MAX_DIM)
        begin
            d = MAX_DIM;
        end
        return COORD_W'(d - 1);
    endfunction

    task automatic clear_sums();
        sum_00 = '0;
        sum_10 = '0;
        sum_01 = '0;
        sum_20 = '0;
        sum_11 = '0;
        sum_02 = '0;
        sum_30 = '0;
        sum_21 = '0;
        sum_12 = '0;
        sum_03 = '0;
    endtask

    task automatic absorb_pixel(input logic [PIX_W-1:0] pv);
        logic [63:0] p;
        logic [63:0] x;
        logic [63:0] y;
        logic        row_done;
        logic        frame_done;
        moments_t    done;
        p = 64'(pv);
        x = 64'(col);
        y = 64'(row);
        sum_00 = ACC00_W'(sum_00 + p);
        sum_10 = ACC10_W'(sum_10 + p * x);
        sum_01 = ACC01_W'(sum_01 + p * y);
        sum_20 = ACC20_W'(sum_20 + p * x * x);
        sum_11 = ACC11_W'(sum_11 + p * x * y);
        sum_02 = ACC02_W'(sum_02 + p * y * y);
        sum_30 = ACC30_W'(sum_30 + p * x * x * x);
        sum_21 = ACC21_W'(sum_21 + p * x * x * y);
        sum_12 = ACC12_W'(sum_12 + p * x * y * y);
        sum_03 = ACC03_W'(sum_03 + p * y * y * y);
        // a size shrunk mid-frame ends the row or frame on the next pixel
        row_done   = (col >= last_coord(width_reg));
        frame_done = row_done && (row >= last_coord(height_reg));
        if (frame_done)
        begin
            done.m00 = sum_00;
            done.m10 = sum_10;
            done.m01 = sum_01;
            done.m20 = sum_20;
            done.m11 = sum_11;
            done.m02 = sum_02;
            done.m30 = sum_30[M30_W-1:0];
            done.m21 = sum_21;
            done.m12 = sum_12;
            done.m03 = sum_03[M03_W-1:0];
            frame_moments_q.push_back(done);
            clear_sums();
            col = '0;
            row = '0;
        end
        else if (row_done)
        begin
            col = '0;
            row = row + COORD_W'(1);
        end
        else
        begin
            col = col + COORD_W'(1);
        end
    endtask

    task automatic check_field(input string tag, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("[%0t] %s mismatch: expected 0x%h, got 0x%h", $realtime, tag,
                         want, got);
            end
        end
    endtask

    task automatic compare_result();
        moments_t want;
        if (frame_moments_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("[%0t] moment transfer with no completed frame pending",
                         $realtime);
            end
        end
        else
        begin
            want = frame_moments_q.pop_front();
            frames_seen++;
            check_field("moment_00", 64'(want.m00), 64'(moment_00));
            check_field("moment_10", 64'(want.m10), 64'(moment_10));
            check_field("moment_01", 64'(want.m01), 64'(moment_01));
            check_field("moment_20", 64'(want.m20), 64'(moment_20));
            check_field("moment_11", 64'(want.m11), 64'(moment_11));
            check_field("moment_02", 64'(want.m02), 64'(moment_02));
            check_field("moment_30", 64'(want.m30), 64'(moment_30));
            check_field("moment_21", 64'(want.m21), 64'(moment_21));
            check_field("moment_12", 64'(want.m12), 64'(moment_12));
            check_field("moment_03", 64'(want.m03), 64'(moment_03));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            col        = '0;
            row        = '0;
            clear_sums();
            frame_moments_q.delete();
            errors      = 0;
            frames_seen = 0;
            mismatch_count <= 0;
            outstanding    <= 0;
            frames_checked <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                begin
                    width_reg = cfg_data;
                end
                else if (cfg_index == REG_IMAGE_HEIGHT)
                begin
                    height_reg = cfg_data;
                end
            end
            if (pixel_valid && pixel_ready)
            begin
                absorb_pixel(pixel);
            end
            if (moment_valid && moment_ready)
            begin
                compare_result();
            end
            mismatch_count <= errors;
            outstanding    <= frame_moments_q.size();
            frames_checked <= frames_seen;
        end
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Top-level bench for raw_image_moment_accumulator_top. Drives frame-size
// writes and raster pixel streams in bursts while the moment receiver stalls;
// a directed opening covers reset size, clamped sizes, saturated and zero
// frames and mid-frame shrinking, then random phases follow.
// ----------------------------------------------------------------------------
module tb;
    import rima_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PIXELS = 2000;
    localparam int MAX_AREA      = 1100;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE
    } ready_mode_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [DIM_W-1:0]     cfg_data     = '0;
    logic                 pixel_valid  = 1'b0;
    logic                 pixel_ready;
    logic [PIX_W-1:0]     pixel        = '0;
    logic                 moment_valid;
    logic                 moment_ready = 1'b0;
    logic [M00_W-1:0]     moment_00;
    logic [M10_W-1:0]     moment_10;
    logic [M01_W-1:0]     moment_01;
    logic [M20_W-1:0]     moment_20;
    logic [M11_W-1:0]     moment_11;
    logic [M02_W-1:0]     moment_02;
    logic [M30_W-1:0]     moment_30;
    logic [M21_W-1:0]     moment_21;
    logic [M12_W-1:0]     moment_12;
    logic [M03_W-1:0]     moment_03;

    int mismatch_count;
    int outstanding;
    int frames_checked;

    ready_mode_t ready_mode  = READY_ALWAYS;
    int          segment_left = 0;
    logic [2:0]  sparse_tick  = '0;

    int cur_w       = MAX_DIM;
    int cur_h       = MAX_DIM;
    int burst_left  = 0;
    int pixels_sent = 0;
    int cfg_writes  = 0;

    raw_image_moment_accumulator_top dut (.*);

    rima_moment_checker checker_i (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver stall pattern, switched between segments
    always @(posedge clk)
    begin
        sparse_tick <= sparse_tick + 3'd1;
        if (segment_left == 0)
        begin
            segment_left <= $urandom_range(16, 96);
            ready_mode   <= ready_mode_t'($urandom_range(0, 2));
        end
        else
        begin
            segment_left <= segment_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS: moment_ready <= 1'b1;
            READY_RANDOM: moment_ready <= 1'($urandom_range(0, 1));
            default:      moment_ready <= (sparse_tick == '0);
        endcase
    end

    function automatic int eff_dim(input int v);
        return (v < 1) ? 1 : ((v > MAX_DIM) ? MAX_DIM : v);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 63);
        case (r)
            0:       return 0;
            1:       return 1;
            2:       return MAX_DIM;
            3:       return $urandom_range(MAX_DIM + 1, 2047);
            4:       return 2047;
            5, 6, 7: return $urandom_range(9, 40);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DIM_W'(data);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
        begin
            cur_w = data;
        end
        else if (idx == REG_IMAGE_HEIGHT)
        begin
            cur_h = data;
        end
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0)
            begin
                pixel_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pixel_valid <= 1'b1;
        pixel       <= value;
        do @(posedge clk); while (!pixel_ready);
        pixels_sent++;
    endtask

    // drain: all frame results back, then let the last pixel finish
    task automatic settle();
        pixel_valid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase();
        int   sel;
        int   nw;
        int   nh;
        int   area;
        int   count;
        logic write_w;
        logic write_h;
        sel     = $urandom_range(0, 7);
        write_w = (sel != 1);
        write_h = (sel != 0);
        nw = write_w ? pick_dim() : cur_w;
        nh = write_h ? pick_dim() : cur_h;
        if (eff_dim(nw) * eff_dim(nh) > MAX_AREA && $urandom_range(0, 3) != 0)
        begin
            if (eff_dim(nw) >= eff_dim(nh))
            begin
                nh = $urandom_range(0, 1);
                write_h = 1'b1;
            end
            else
            begin
                nw = $urandom_range(0, 1);
                write_w = 1'b1;
            end
        end
        if (sel == 2)
        begin
            write_reg(CFG_IDX_W'($urandom_range(2, 15)), $urandom_range(0, 2047));
        end
        if (write_w)
        begin
            write_reg(REG_IMAGE_WIDTH, nw);
        end
        if (write_h)
        begin
            write_reg(REG_IMAGE_HEIGHT, nh);
        end
        area = eff_dim(cur_w) * eff_dim(cur_h);
        if (area > MAX_AREA)
        begin
            // partial frame only; a later smaller size closes it
            count = $urandom_range(1, 300);
        end
        else
        begin
            count = ((area <= 64) ? $urandom_range(1, 4) : 1) * area;
            if ($urandom_range(0, 3) == 0)
            begin
                count += $urandom_range(1, (area > 40) ? 40 : area);
            end
        end
        repeat (count)
        begin
            push_pixel(pick_pixel());
        end
        settle();
    endtask

    initial
    begin
        int directed_pixels;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size: a short partial row, no result
        push_pixel('1);
        push_pixel('0);
        push_pixel(8'd170);
        settle();
        // shrink to 1x1 mid-frame: next pixel closes the frame
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, 1);
        push_pixel('1);
        settle();
        // zero sizes count as one
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 0);
        push_pixel('1);
        push_pixel(8'd1);
        settle();
        // saturated frame, then an all-zero frame
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 2);
        repeat (6) push_pixel('1);
        repeat (6) push_pixel('0);
        settle();
        // height shrunk below the current row
        write_reg(REG_IMAGE_WIDTH, 2);
        write_reg(REG_IMAGE_HEIGHT, 3);
        push_pixel(8'd128);
        push_pixel(8'd64);
        push_pixel(8'd32);
        settle();
        write_reg(REG_IMAGE_HEIGHT, 1);
        push_pixel('1);
        settle();

        directed_pixels = pixels_sent;
        while (pixels_sent - directed_pixels < RANDOM_PIXELS)
        begin
            random_phase();
        end

        $display("Sent %0d pixels with %0d register writes; %0d frame results compared.",
                 pixels_sent, cfg_writes, frames_checked);
        if (mismatch_count == 0 && outstanding == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rima_pkg.sv
hw/rtl/rima_ctrl.sv
hw/rtl/rima_datapath.sv
hw/rtl/raw_image_moment_accumulator_top.sv
hw/rtl/rima_checker.sv
sim/rima_moment_checker.sv
sim/tb.sv
